FILE: hdl/tlpw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tlpw_pkg;

	localparam int MEM_BYTES  = 4096;
	localparam int PAGE_BYTES = 32;
	localparam int MEM_AW     = $clog2(MEM_BYTES);
	localparam int OFF_W      = $clog2(PAGE_BYTES);
	localparam int FRAME_W    = MEM_AW - OFF_W;
	localparam int VA_W       = 15;
	localparam int ENTRY_V    = 7;

	localparam logic [MEM_AW-1:0] BASE_RESET = MEM_AW'(12'h220);

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_DIR_FAULT = 2'd1,
		ST_TAB_FAULT = 2'd2,
		ST_LOAD      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		AS_DIR,
		AS_TAB,
		AS_DATA
	} addr_sel_t;

	typedef enum logic [2:0] {
		CD_NONE,
		CD_NO_IN,
		CD_IS_LOAD,
		CD_DIR_BAD,
		CD_TAB_BAD,
		CD_OUT_BUSY
	} cond_t;

	typedef logic [2:0] upc_t;

	localparam upc_t U_IDLE    = 3'd0;
	localparam upc_t U_DIR_RD  = 3'd1;
	localparam upc_t U_DIR_CHK = 3'd2;
	localparam upc_t U_TAB_CHK = 3'd3;
	localparam upc_t U_DATA    = 3'd4;
	localparam upc_t U_LOAD    = 3'd5;
	localparam upc_t U_FIN_DIR = 3'd6;
	localparam upc_t U_FIN_TAB = 3'd7;

	typedef struct packed {
		addr_sel_t addr_sel;
		logic      rd;
		logic      we;
		logic      cap_dir;
		logic      cap_tab;
		logic      emit;
		logic      last;
		cond_t     cond;
		upc_t      target;
		status_t   status;
	} ctl_word_t;

	// the walk program, one control word per step
	function automatic ctl_word_t ucode_rom(upc_t pc);
		ctl_word_t w;
		w = '{addr_sel: AS_DIR, rd: 1'b0, we: 1'b0, cap_dir: 1'b0, cap_tab: 1'b0,
			emit: 1'b0, last: 1'b0, cond: CD_NONE, target: U_IDLE, status: ST_OK};
		case (pc)
			U_IDLE: begin
				w.cond   = CD_NO_IN;
				w.target = U_IDLE;
			end
			U_DIR_RD: begin
				w.addr_sel = AS_DIR;
				w.rd       = 1'b1;
				w.cond     = CD_IS_LOAD;
				w.target   = U_LOAD;
			end
			U_DIR_CHK: begin
				w.addr_sel = AS_TAB;
				w.rd       = 1'b1;
				w.cap_dir  = 1'b1;
				w.cond     = CD_DIR_BAD;
				w.target   = U_FIN_DIR;
			end
			U_TAB_CHK: begin
				w.addr_sel = AS_DATA;
				w.rd       = 1'b1;
				w.cap_tab  = 1'b1;
				w.cond     = CD_TAB_BAD;
				w.target   = U_FIN_TAB;
			end
			U_DATA: begin
				w.emit   = 1'b1;
				w.last   = 1'b1;
				w.cond   = CD_OUT_BUSY;
				w.target = U_DATA;
				w.status = ST_OK;
			end
			U_LOAD: begin
				w.we     = 1'b1;
				w.emit   = 1'b1;
				w.last   = 1'b1;
				w.cond   = CD_OUT_BUSY;
				w.target = U_LOAD;
				w.status = ST_LOAD;
			end
			U_FIN_DIR: begin
				w.emit   = 1'b1;
				w.last   = 1'b1;
				w.cond   = CD_OUT_BUSY;
				w.target = U_FIN_DIR;
				w.status = ST_DIR_FAULT;
			end
			U_FIN_TAB: begin
				w.emit   = 1'b1;
				w.last   = 1'b1;
				w.cond   = CD_OUT_BUSY;
				w.target = U_FIN_TAB;
				w.status = ST_TAB_FAULT;
			end
			default: begin
				w.cond   = CD_NONE;
				w.target = U_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/two_level_page_walk_top.sv
// channel   | signals                             | direction
// ----------+-------------------------------------+----------
// input     | in_valid, in_ready, op, address,    | in
//           | write_byte                          |
// result    | out_valid, out_ready, status,       | out
//           | dir_index, dir_valid, dir_frame,    |
//           | table_index, table_valid,           |
//           | table_frame, phys_addr, read_byte   |
// config    | cfg_valid, cfg_ready, directory_base| in
//
// a translate item does three dependent reads of the one synchronous memory port,
// then the result step; a load writes and issues its result after the first read,
// a directory fault after the second, a table fault after the third; the sequencer
// returns to its idle step as the result is registered
// arst_n clears the sequencer and the result registers and sets the directory base to 0x220;
// the memory is not cleared
// input is taken only when the sequencer is at its idle step; a stalled result
// holds the sequencer at its result step
`timescale 1ns / 1ps
`default_nettype none

module two_level_page_walk_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          op,
	input  wire logic [tlpw_pkg::VA_W-1:0]     address,
	input  wire logic [7:0]                    write_byte,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [1:0]                         status,
	output logic [tlpw_pkg::OFF_W-1:0]         dir_index,
	output logic                               dir_valid,
	output logic [tlpw_pkg::FRAME_W-1:0]       dir_frame,
	output logic [tlpw_pkg::OFF_W-1:0]         table_index,
	output logic                               table_valid,
	output logic [tlpw_pkg::FRAME_W-1:0]       table_frame,
	output logic [tlpw_pkg::MEM_AW-1:0]        phys_addr,
	output logic [7:0]                         read_byte,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [tlpw_pkg::MEM_AW-1:0]   directory_base
);
	import tlpw_pkg::*;

	upc_t                upc_q;
	ctl_word_t           ctl;
	logic                in_xfer;
	logic                out_busy;
	logic                cond_met;
	logic                emit_go;
	logic                mem_we;

	logic [MEM_AW-1:0]   base_q;
	logic                op_q;
	logic [VA_W-1:0]     addr_q;
	logic [7:0]          wbyte_q;
	logic [FRAME_W-1:0]  dir_f_q;
	logic [FRAME_W-1:0]  tab_f_q;
	logic [7:0]          rdata_q;
	logic [MEM_AW-1:0]   raddr;
	logic [7:0]          mem [MEM_BYTES];

	logic [OFF_W-1:0]    dir_idx;
	logic [OFF_W-1:0]    tab_idx;
	logic [OFF_W-1:0]    page_off;

	logic [OFF_W-1:0]    res_dir_index;
	logic                res_dir_valid;
	logic [FRAME_W-1:0]  res_dir_frame;
	logic [OFF_W-1:0]    res_table_index;
	logic                res_table_valid;
	logic [FRAME_W-1:0]  res_table_frame;
	logic [MEM_AW-1:0]   res_phys_addr;
	logic [7:0]          res_read_byte;

	assign dir_idx  = addr_q[VA_W-1 -: OFF_W];
	assign tab_idx  = addr_q[2*OFF_W-1 -: OFF_W];
	assign page_off = addr_q[OFF_W-1:0];

	assign ctl       = ucode_rom(upc_q);
	assign in_ready  = (upc_q == U_IDLE);
	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && in_ready;
	assign out_busy  = out_valid && !out_ready;
	assign emit_go   = ctl.emit && !out_busy;
	assign mem_we    = ctl.we && !out_busy;

	always_comb begin
		case (ctl.cond)
			CD_NONE:     cond_met = 1'b0;
			CD_NO_IN:    cond_met = !in_xfer;
			CD_IS_LOAD:  cond_met = !op_q;
			CD_DIR_BAD:  cond_met = !rdata_q[ENTRY_V];
			CD_TAB_BAD:  cond_met = !rdata_q[ENTRY_V];
			CD_OUT_BUSY: cond_met = out_busy;
			default:     cond_met = 1'b0;
		endcase
	end

	// entry addresses are page number and index side by side, so no carry
	always_comb begin
		case (ctl.addr_sel)
			AS_DIR:  raddr = {base_q[MEM_AW-1:OFF_W], dir_idx};
			AS_TAB:  raddr = {rdata_q[FRAME_W-1:0], tab_idx};
			AS_DATA: raddr = {rdata_q[FRAME_W-1:0], page_off};
			default: raddr = '0;
		endcase
	end

	always_comb begin
		res_dir_index   = '0;
		res_dir_valid   = 1'b0;
		res_dir_frame   = '0;
		res_table_index = '0;
		res_table_valid = 1'b0;
		res_table_frame = '0;
		res_phys_addr   = '0;
		res_read_byte   = '0;
		case (ctl.status)
			ST_OK: begin
				res_dir_index   = dir_idx;
				res_dir_valid   = 1'b1;
				res_dir_frame   = dir_f_q;
				res_table_index = tab_idx;
				res_table_valid = 1'b1;
				res_table_frame = tab_f_q;
				res_phys_addr   = {tab_f_q, page_off};
				res_read_byte   = rdata_q;
			end
			ST_DIR_FAULT: begin
				res_dir_index   = dir_idx;
				res_dir_frame   = dir_f_q;
				res_table_index = tab_idx;
			end
			ST_TAB_FAULT: begin
				res_dir_index   = dir_idx;
				res_dir_valid   = 1'b1;
				res_dir_frame   = dir_f_q;
				res_table_index = tab_idx;
				res_table_frame = tab_f_q;
			end
			ST_LOAD: begin
				res_phys_addr   = addr_q[MEM_AW-1:0];
				res_read_byte   = wbyte_q;
			end
			default: begin
				res_read_byte   = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr_q[MEM_AW-1:0]] <= wbyte_q;
		end
		if (ctl.rd) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q    <= op;
			addr_q  <= address;
			wbyte_q <= write_byte;
		end
		if (ctl.cap_dir) begin
			dir_f_q <= rdata_q[FRAME_W-1:0];
		end
		if (ctl.cap_tab) begin
			tab_f_q <= rdata_q[FRAME_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= U_IDLE;
			base_q      <= BASE_RESET;
			out_valid   <= 1'b0;
			status      <= '0;
			dir_index   <= '0;
			dir_valid   <= 1'b0;
			dir_frame   <= '0;
			table_index <= '0;
			table_valid <= 1'b0;
			table_frame <= '0;
			phys_addr   <= '0;
			read_byte   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				base_q <= directory_base;
			end

			if (cond_met) begin
				upc_q <= ctl.target;
			end else if (ctl.last) begin
				upc_q <= U_IDLE;
			end else begin
				upc_q <= upc_q + upc_t'(1);
			end

			if (emit_go) begin
				out_valid   <= 1'b1;
				status      <= ctl.status;
				dir_index   <= res_dir_index;
				dir_valid   <= res_dir_valid;
				dir_frame   <= res_dir_frame;
				table_index <= res_table_index;
				table_valid <= res_table_valid;
				table_frame <= res_table_frame;
				phys_addr   <= res_phys_addr;
				read_byte   <= res_read_byte;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_xfer_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (upc_q == U_DIR_RD))
		else $error("input transfer did not start the walk");

	a_data_after_table: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == U_DATA) |-> ($past(upc_q) == U_TAB_CHK || $past(upc_q) == U_DATA))
		else $error("data step reached without a table check");

	a_write_only_load: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !op_q)
		else $error("memory write during a translate item");

	a_ok_both_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_OK) |-> (dir_valid && table_valid))
		else $error("translated result without valid entries");
`endif

endmodule

`default_nettype wire
